FILE: rtl/snp_pkg.sv
// shared types and constants for the segment nearest point pipeline
// no dependencies; imported by the divider, square root, top level and testbench
package snp_pkg;

    localparam int DIV_STEPS  = 17;
    localparam int SQRT_STEPS = 33;

    localparam logic [16:0] T_ONE = 17'h10000;

    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_END_X   = 2'd2;
    localparam logic [1:0] REG_END_Y   = 2'd3;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_ONE,
        MODE_DIV
    } mode_t;

    // data riding alongside the divider
    typedef struct packed {
        logic               deg;
        logic               left;
        logic signed [31:0] qx;
        logic signed [31:0] qy;
    } div_side_t;

    // data riding alongside the square root
    typedef struct packed {
        logic               deg;
        logic               left;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic        [16:0] t;
    } sqrt_side_t;

endpackage

FILE: rtl/snp_divider.sv
// pipelined restoring divider for the segment parameter, one quotient bit per stage
// depends on snp_pkg
module snp_divider
    import snp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [67:0] in_rem,
    input  logic [65:0] in_lsq,
    input  mode_t       in_mode,
    input  div_side_t   in_side,
    output logic        out_vld,
    output logic [16:0] out_q,
    output mode_t       out_mode,
    output div_side_t   out_side
);

    logic        vld_reg  [DIV_STEPS];
    logic [67:0] rem_reg  [DIV_STEPS];
    logic [16:0] q_reg    [DIV_STEPS];
    logic [65:0] lsq_reg  [DIV_STEPS];
    mode_t       mode_reg [DIV_STEPS];
    div_side_t   side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
        logic        vld_in;
        logic [67:0] rem_in;
        logic [16:0] q_in;
        logic [65:0] lsq_in;
        mode_t       mode_in;
        div_side_t   side_in;
        logic [67:0] shifted;
        logic        ge;
        logic [67:0] rem_next;
        logic [16:0] q_next;

        if (k == 0) begin : g_first
            assign vld_in  = in_vld;
            assign rem_in  = in_rem;
            assign q_in    = '0;
            assign lsq_in  = in_lsq;
            assign mode_in = in_mode;
            assign side_in = in_side;
        end
        else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign lsq_in  = lsq_reg[k-1];
            assign mode_in = mode_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign shifted  = {rem_in[66:0], 1'b0};
        assign ge       = shifted >= {2'b00, lsq_in};
        assign rem_next = ge ? (shifted - {2'b00, lsq_in}) : shifted;
        assign q_next   = {q_in[15:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                lsq_reg[k]  <= lsq_in;
                mode_reg[k] <= mode_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STEPS-1];
    assign out_q    = q_reg[DIV_STEPS-1];
    assign out_mode = mode_reg[DIV_STEPS-1];
    assign out_side = side_reg[DIV_STEPS-1];

endmodule

FILE: rtl/snp_sqrt.sv
// pipelined digit-by-digit integer square root, one root bit per stage
// depends on snp_pkg; returns floor root and final remainder
module snp_sqrt
    import snp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_vld,
    input  logic [65:0] in_n,
    input  sqrt_side_t  in_side,
    output logic        out_vld,
    output logic [32:0] out_root,
    output logic [35:0] out_rem,
    output sqrt_side_t  out_side
);

    logic        vld_reg  [SQRT_STEPS];
    logic [65:0] n_reg    [SQRT_STEPS];
    logic [35:0] rem_reg  [SQRT_STEPS];
    logic [32:0] root_reg [SQRT_STEPS];
    sqrt_side_t  side_reg [SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
        logic        vld_in;
        logic [65:0] n_in;
        logic [35:0] rem_in;
        logic [32:0] root_in;
        sqrt_side_t  side_in;
        logic [35:0] rem_try;
        logic [35:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign vld_in  = in_vld;
            assign n_in    = in_n;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign n_in    = n_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next pair of radicand bits
        assign rem_try = {rem_in[33:0], n_in[65:64]};
        assign trial   = {1'b0, root_in, 2'b01};
        assign ge      = rem_try >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= {n_in[63:0], 2'b00};
                rem_reg[k]  <= ge ? (rem_try - trial) : rem_try;
                root_reg[k] <= {root_in[31:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STEPS-1];
    assign out_root = root_reg[SQRT_STEPS-1];
    assign out_rem  = rem_reg[SQRT_STEPS-1];
    assign out_side = side_reg[SQRT_STEPS-1];

endmodule

FILE: rtl/segment_nearest_point_unit.sv
// top level of the segment nearest point unit: config registers and pipeline
// depends on snp_pkg, snp_divider and snp_sqrt
//
// usage
//  - configuration: write start_x, start_y, end_x, end_y (index 0..3) on the
//    cfg channel while the pipeline is empty; cfg_ready is always high
//  - input: query_x/query_y transfer on in_valid & in_ready
//  - output: near_x, near_y, near_t, signed_dist, segment_valid transfer on
//    out_valid & out_ready
//  - results pass p1 to p3, the 17 stage divider for t, p4 to p9, the
//    33 stage square root for the distance and the output stage, one
//    result bit per stage in divider and root; one query is taken every
//    cycle while the receiver keeps up
//  - when the receiver stalls with a result waiting, the whole pipeline
//    holds and in_ready drops; nothing is lost or repeated
//  - reset clears all valid bits and sets the four registers to zero
//  - a zero-length segment gives segment_valid low and zero results
module segment_nearest_point_unit
    import snp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] query_x,
    input  logic signed [31:0] query_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] near_x,
    output logic signed [31:0] near_y,
    output logic        [16:0] near_t,
    output logic signed [31:0] signed_dist,
    output logic               segment_valid
);

    logic signed [31:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic signed [32:0] dx, dy;
    logic               en;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            end_x_reg   <= '0;
            end_y_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // the user must keep the registers steady whenever items are in flight; the block does not enforce it
    assign dx = {end_x_reg[31], end_x_reg} - {start_x_reg[31], start_x_reg};
    assign dy = {end_y_reg[31], end_y_reg} - {start_y_reg[31], start_y_reg};

    logic out_vld_reg;
    assign en        = !out_vld_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_vld_reg;

    // p1: offsets from start
    logic               p1_vld_reg, p1_deg_reg;
    logic signed [31:0] p1_qx_reg, p1_qy_reg;
    logic signed [32:0] p1_sx_reg, p1_sy_reg, p1_dx_reg, p1_dy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_qx_reg  <= query_x;
            p1_qy_reg  <= query_y;
            p1_sx_reg  <= {query_x[31], query_x} - {start_x_reg[31], start_x_reg};
            p1_sy_reg  <= {query_y[31], query_y} - {start_y_reg[31], start_y_reg};
            p1_dx_reg  <= dx;
            p1_dy_reg  <= dy;
            p1_deg_reg <= (dx == '0) && (dy == '0);
        end
    end

    // p2: products
    logic               p2_vld_reg, p2_deg_reg;
    logic signed [31:0] p2_qx_reg, p2_qy_reg;
    logic signed [65:0] p2_pdx_reg, p2_pdy_reg, p2_lx_reg, p2_ly_reg, p2_cx_reg, p2_cy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p2_vld_reg <= p1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_qx_reg  <= p1_qx_reg;
            p2_qy_reg  <= p1_qy_reg;
            p2_deg_reg <= p1_deg_reg;
            p2_pdx_reg <= p1_sx_reg * p1_dx_reg;
            p2_pdy_reg <= p1_sy_reg * p1_dy_reg;
            p2_lx_reg  <= p1_dx_reg * p1_dx_reg;
            p2_ly_reg  <= p1_dy_reg * p1_dy_reg;
            p2_cx_reg  <= p1_dx_reg * p1_sy_reg;
            p2_cy_reg  <= p1_dy_reg * p1_sx_reg;
        end
    end

    // p3: dot, squared length, side and clamp decision
    logic signed [66:0] dot, cross_prod;
    logic        [65:0] lsq;
    mode_t              mode;

    assign dot        = {p2_pdx_reg[65], p2_pdx_reg} + {p2_pdy_reg[65], p2_pdy_reg};
    assign cross_prod = {p2_cx_reg[65], p2_cx_reg} - {p2_cy_reg[65], p2_cy_reg};
    assign lsq        = p2_lx_reg[65:0] + p2_ly_reg[65:0];

    always_comb
    begin
        if (dot[66] || dot == '0)
            mode = MODE_ZERO;
        else if (dot[65:0] >= lsq)
            mode = MODE_ONE;
        else
            mode = MODE_DIV;
    end

    logic               p3_vld_reg;
    logic        [67:0] p3_rem_reg;
    logic        [65:0] p3_lsq_reg;
    mode_t              p3_mode_reg;
    div_side_t          p3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_rem_reg       <= {1'b0, dot};
            p3_lsq_reg       <= lsq;
            p3_mode_reg      <= mode;
            p3_side_reg.deg  <= p2_deg_reg;
            p3_side_reg.left <= !cross_prod[66] && (cross_prod != '0);
            p3_side_reg.qx   <= p2_qx_reg;
            p3_side_reg.qy   <= p2_qy_reg;
        end
    end

    logic        dv_vld;
    logic [16:0] dv_q;
    mode_t       dv_mode;
    div_side_t   dv_side;

    snp_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p3_vld_reg),
        .in_rem   (p3_rem_reg),
        .in_lsq   (p3_lsq_reg),
        .in_mode  (p3_mode_reg),
        .in_side  (p3_side_reg),
        .out_vld  (dv_vld),
        .out_q    (dv_q),
        .out_mode (dv_mode),
        .out_side (dv_side)
    );

    // p4: clamped, rounded t
    logic        [17:0] q_inc;
    logic        [16:0] t_val;
    assign q_inc = {1'b0, dv_q} + 18'd1;

    always_comb
    begin
        case (dv_mode)
            MODE_ZERO: t_val = '0;
            MODE_ONE:  t_val = T_ONE;
            MODE_DIV:  t_val = q_inc[17:1];
            default:   t_val = '0;
        endcase
    end

    logic               p4_vld_reg;
    logic        [16:0] p4_t_reg;
    div_side_t          p4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p4_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_t_reg    <= t_val;
            p4_side_reg <= dv_side;
        end
    end

    // p5: direction scaled by t
    logic               p5_vld_reg;
    logic        [16:0] p5_t_reg;
    div_side_t          p5_side_reg;
    logic signed [50:0] p5_px_reg, p5_py_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p5_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_t_reg    <= p4_t_reg;
            p5_side_reg <= p4_side_reg;
            p5_px_reg   <= dx * $signed({1'b0, p4_t_reg});
            p5_py_reg   <= dy * $signed({1'b0, p4_t_reg});
        end
    end

    // p6: nearest point, rounded half up and saturated
    logic signed [50:0] rx_sum, ry_sum;
    logic signed [34:0] nx_wide, ny_wide;
    logic signed [31:0] nx_sat, ny_sat;

    assign rx_sum  = p5_px_reg + 51'sd32768;
    assign ry_sum  = p5_py_reg + 51'sd32768;
    assign nx_wide = {{3{start_x_reg[31]}}, start_x_reg} + rx_sum[50:16];
    assign ny_wide = {{3{start_y_reg[31]}}, start_y_reg} + ry_sum[50:16];

    always_comb
    begin
        if (nx_wide > 35'sh0_7FFF_FFFF)
            nx_sat = 32'sh7FFF_FFFF;
        else if (nx_wide < -35'sh0_8000_0000)
            nx_sat = 32'sh8000_0000;
        else
            nx_sat = nx_wide[31:0];
        if (ny_wide > 35'sh0_7FFF_FFFF)
            ny_sat = 32'sh7FFF_FFFF;
        else if (ny_wide < -35'sh0_8000_0000)
            ny_sat = 32'sh8000_0000;
        else
            ny_sat = ny_wide[31:0];
    end

    logic               p6_vld_reg;
    sqrt_side_t         p6_side_reg;
    logic signed [31:0] p6_qx_reg, p6_qy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p6_vld_reg <= p5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p6_side_reg.deg  <= p5_side_reg.deg;
            p6_side_reg.left <= p5_side_reg.left;
            p6_side_reg.nx   <= nx_sat;
            p6_side_reg.ny   <= ny_sat;
            p6_side_reg.t    <= p5_t_reg;
            p6_qx_reg        <= p5_side_reg.qx;
            p6_qy_reg        <= p5_side_reg.qy;
        end
    end

    // p7: error vector
    logic               p7_vld_reg;
    sqrt_side_t         p7_side_reg;
    logic signed [32:0] p7_ex_reg, p7_ey_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p7_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p7_vld_reg <= p6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p7_side_reg <= p6_side_reg;
            p7_ex_reg   <= {p6_qx_reg[31], p6_qx_reg} - {p6_side_reg.nx[31], p6_side_reg.nx};
            p7_ey_reg   <= {p6_qy_reg[31], p6_qy_reg} - {p6_side_reg.ny[31], p6_side_reg.ny};
        end
    end

    // p8: squares
    logic               p8_vld_reg;
    sqrt_side_t         p8_side_reg;
    logic signed [65:0] p8_ex2_reg, p8_ey2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p8_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p8_vld_reg <= p7_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p8_side_reg <= p7_side_reg;
            p8_ex2_reg  <= p7_ex_reg * p7_ex_reg;
            p8_ey2_reg  <= p7_ey_reg * p7_ey_reg;
        end
    end

    // p9: squared distance
    logic               p9_vld_reg;
    sqrt_side_t         p9_side_reg;
    logic        [65:0] p9_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p9_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p9_vld_reg <= p8_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p9_side_reg <= p8_side_reg;
            p9_n_reg    <= p8_ex2_reg[65:0] + p8_ey2_reg[65:0];
        end
    end

    logic        sq_vld;
    logic [32:0] sq_root;
    logic [35:0] sq_rem;
    sqrt_side_t  sq_side;

    snp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (p9_vld_reg),
        .in_n     (p9_n_reg),
        .in_side  (p9_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_rem  (sq_rem),
        .out_side (sq_side)
    );

    // output stage: round the root, saturate, apply side, zero a degenerate segment
    logic [33:0] root_rnd;
    logic [30:0] dist_mag;
    logic [31:0] dist_val;

    assign root_rnd = {1'b0, sq_root} + {33'd0, (sq_rem > {3'b000, sq_root})};
    assign dist_mag = (root_rnd > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : root_rnd[30:0];
    assign dist_val = sq_side.left ? {1'b0, dist_mag} : (32'd0 - {1'b0, dist_mag});

    logic signed [31:0] near_x_reg, near_y_reg, dist_reg;
    logic        [16:0] near_t_reg;
    logic               seg_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_vld_reg <= !sq_side.deg;
            near_x_reg  <= sq_side.deg ? '0 : sq_side.nx;
            near_y_reg  <= sq_side.deg ? '0 : sq_side.ny;
            near_t_reg  <= sq_side.deg ? '0 : sq_side.t;
            dist_reg    <= sq_side.deg ? '0 : dist_val;
        end
    end

    assign near_x        = near_x_reg;
    assign near_y        = near_y_reg;
    assign near_t        = near_t_reg;
    assign signed_dist   = dist_reg;
    assign segment_valid = seg_vld_reg;

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !segment_valid |-> near_t == '0 && signed_dist == '0
            && near_x == '0 && near_y == '0)
        else $error("degenerate segment gave non-zero result");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> near_t <= T_ONE)
        else $error("segment parameter beyond one");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result stalled");
`endif

endmodule

FILE: test/testbench.sv
// self-checking bench for segment_nearest_point_unit: directed table then random queries
// depends on snp_pkg and the rtl of segment_nearest_point_unit
module testbench
    import snp_pkg::*;
;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] near_x;
    logic signed [31:0] near_y;
    logic        [16:0] near_t;
    logic signed [31:0] signed_dist;
    logic               segment_valid;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic        [16:0] t;
        logic signed [31:0] sd;
        logic               sv;
    } proj_t;

    typedef struct {
        logic signed [31:0] qx;
        logic signed [31:0] qy;
        bit                 typed;
        proj_t              want;
    } query_row_t;

    localparam int LATENCY   = 60;
    localparam int CYCLE_CAP = 1500000;

    logic signed [31:0] seg_ax, seg_ay, seg_bx, seg_by;
    proj_t              pending_proj[$];
    int                 errors = 0;
    int                 cycles = 0;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_req;
    bit                 hold_done;
    int                 hold_cnt;

    segment_nearest_point_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic signed [63:0] round_q16(logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + 64'sd32768;
        return s >>> 16;
    endfunction

    function automatic logic signed [31:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root_round(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] rem;
        r = 0;
        for (int b = 34; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            if (n >= 128'(c) * 128'(c))
                r = c;
        end
        rem = n - 128'(r) * 128'(r);
        if (rem > 128'(r))
            r = r + 1;
        return r;
    endfunction

    function automatic proj_t project(logic signed [31:0] qx, logic signed [31:0] qy);
        proj_t                res;
        logic signed [63:0]   dx, dy, sx, sy, ex, ey;
        logic signed [127:0]  dot, lsq, cr;
        logic [127:0]         q;
        logic [63:0]          r;
        logic [16:0]          t;
        res = '0;
        dx = 64'(seg_bx) - 64'(seg_ax);
        dy = 64'(seg_by) - 64'(seg_ay);
        if (dx == 0 && dy == 0)
            return res;
        sx = 64'(qx) - 64'(seg_ax);
        sy = 64'(qy) - 64'(seg_ay);
        dot = 128'(sx) * 128'(dx) + 128'(sy) * 128'(dy);
        lsq = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        if (dot <= 0)
            t = 0;
        else if (dot >= lsq)
            t = T_ONE;
        else
        begin
            // 17 quotient bits, then halve with rounding
            q = (dot <<< 17) / lsq;
            t = 17'((q + 1) >> 1);
        end
        res.t  = t;
        res.nx = clip32(64'(seg_ax) + round_q16(dx * $signed({47'd0, t})));
        res.ny = clip32(64'(seg_ay) + round_q16(dy * $signed({47'd0, t})));
        ex = 64'(qx) - 64'(res.nx);
        ey = 64'(qy) - 64'(res.ny);
        // squares can exceed the signed 64 bit range
        r = root_round(128'(ex) * 128'(ex) + 128'(ey) * 128'(ey));
        if (r > 64'd2147483647)
            r = 64'd2147483647;
        cr = 128'(dx) * 128'(sy) - 128'(dy) * 128'(sx);
        res.sd = (cr > 0) ? r[31:0] : -$signed(r[31:0]);
        res.sv = 1'b1;
        return res;
    endfunction

    // leaves cfg_valid high so that writes can follow back to back
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_START_X: seg_ax = val;
            REG_START_Y: seg_ay = val;
            REG_END_X:   seg_bx = val;
            default:     seg_by = val;
        endcase
    endtask

    task automatic set_segment(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                               logic [31:0] by);
        wait (pending_proj.size() == 0);
        repeat (LATENCY + 4) @(posedge clk);
        write_reg(REG_START_X, ax);
        write_reg(REG_START_Y, ay);
        write_reg(REG_END_X, bx);
        write_reg(REG_END_Y, by);
        cfg_valid <= 1'b0;
    endtask

    task automatic offer_query(logic signed [31:0] qx, logic signed [31:0] qy);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        query_x  <= qx;
        query_y  <= qy;
        do
            @(posedge clk);
        while (!in_ready);
        pending_proj.push_back(project(qx, qy));
    endtask

    task automatic query_done();
        in_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 32'($signed($urandom_range(0, 200000)) - 100000) <<< 8;
        endcase
    endfunction

    // expected projection check at the output
    always @(posedge clk)
    begin
        proj_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_proj.size() == 0)
            begin
                $error("result with no query outstanding");
                errors++;
            end
            else
            begin
                want = pending_proj.pop_front();
                if (near_x !== want.nx)
                begin
                    $error("near_x expected %0d got %0d", want.nx, near_x);
                    errors++;
                end
                if (near_y !== want.ny)
                begin
                    $error("near_y expected %0d got %0d", want.ny, near_y);
                    errors++;
                end
                if (near_t !== want.t)
                begin
                    $error("near_t expected %0d got %0d", want.t, near_t);
                    errors++;
                end
                if (signed_dist !== want.sd)
                begin
                    $error("signed_dist expected %0d got %0d", want.sd, signed_dist);
                    errors++;
                end
                if (segment_valid !== want.sv)
                begin
                    $error("segment_valid expected %0d got %0d", want.sv, segment_valid);
                    errors++;
                end
            end
        end
    end

    // receiver stalls, with one long hold-off when requested
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_cnt  <= 300;
            hold_done <= 1'b1;
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        query_row_t rows[$];
        query_row_t row;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        query_x        = '0;
        query_y        = '0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        seg_ax = 0; seg_ay = 0; seg_bx = 0; seg_by = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset the segment is degenerate: all zero, segment_valid low
        rows.push_back('{32'sh7fffffff, 32'sh80000000, 1'b1, '0});
        rows.push_back('{32'sh00010000, 32'sh00020000, 1'b1, '0});
        foreach (rows[i])
            offer_query(rows[i].qx, rows[i].qy);
        query_done();

        // unit segment along x: before start, after end, interior, left, right, on line
        set_segment(32'sh0, 32'sh0, 32'sh00010000, 32'sh0);
        rows.delete();
        rows.push_back('{-32'sh00010000, 32'sh0, 1'b1, '{0, 0, 0, -32'sh00010000, 1}});
        rows.push_back('{32'sh00030000, 32'sh0, 1'b1,
                         '{32'sh00010000, 0, T_ONE, -32'sh00020000, 1}});
        rows.push_back('{32'sh00008000, 32'sh00010000, 1'b1,
                         '{32'sh00008000, 0, 17'h08000, 32'sh00010000, 1}});
        rows.push_back('{32'sh00008000, -32'sh00010000, 1'b1,
                         '{32'sh00008000, 0, 17'h08000, -32'sh00010000, 1}});
        rows.push_back('{32'sh00004000, 32'sh0, 1'b0, '0});
        rows.push_back('{32'sh7fffffff, 32'sh7fffffff, 1'b0, '0});
        rows.push_back('{32'sh80000000, 32'sh80000000, 1'b0, '0});
        rows.push_back('{32'sh80000000, 32'sh7fffffff, 1'b0, '0});
        rows.push_back('{32'sh00005555, 32'sh00000001, 1'b0, '0});
        foreach (rows[i])
        begin
            row = rows[i];
            offer_query(row.qx, row.qy);
            if (row.typed)
                pending_proj[$] = row.want;
        end
        query_done();

        // extreme segment corner to corner; distance saturates
        set_segment(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
        offer_query(32'sh80000000, 32'sh7fffffff);
        offer_query(32'sh7fffffff, 32'sh80000000);
        offer_query(32'sh0, 32'sh0);
        offer_query(32'sh12345678, -32'sh0abcdef0);
        query_done();
        set_segment(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
        offer_query(32'sh80000000, 32'sh80000000);
        offer_query(32'sh7fffffff, 32'sh7fffffff);
        offer_query(32'sh00000001, -32'sh00000001);
        query_done();

        // random phases over several segments and idling mixes
        for (int ph = 0; ph < 10; ph++)
        begin
            int mode;
            mode = ph % 3;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            if (ph == 7)
                set_segment(32'sh00050000, -32'sh00030000, 32'sh00050000, -32'sh00030000);
            else
                set_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                            rand_coord(mode));
            if (ph == 4)
                hold_req = 1'b1;
            for (int k = 0; k < 110; k++)
            begin
                if (mode == 0 || $urandom_range(3) == 0)
                    offer_query($urandom, $urandom);
                else
                    offer_query(32'($signed(seg_ax) + $signed(rand_coord(1))),
                                32'($signed(seg_ay) + $signed(rand_coord(1))));
            end
            query_done();
        end

        wait (pending_proj.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/snp_pkg.sv
rtl/snp_divider.sv
rtl/snp_sqrt.sv
rtl/segment_nearest_point_unit.sv
test/testbench.sv
